/* design/dta_pkg.sv */
// ----------------------------------------------------------------------------
// dta_pkg: shared types and constants for the duty time accumulator
// Holds the action and result kind codes, the divide-by-1000 constants and
// the structs that carry an item from stage to stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dta_pkg;

  // Stream widths: fields packed from bit 0 up, tdata padded to whole bytes.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 1;

  localparam int TIME_W = 32;
  localparam int FRAC_W = 10;
  localparam int QUOT_W = 23;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_PERSIST_ENABLE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_LAST_DUTY = 1'b1;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [TIME_W-1:0] MS_PER_SECOND = 32'd1000;
  localparam logic [TIME_W-1:0] RECIP_1000    = 32'h8312_6E98;
  localparam int                RECIP_SHIFT   = 41;

  typedef enum logic [1:0] {
    ACT_OBSERVE   = 2'd0,
    ACT_ON_CHANGE = 2'd1,
    ACT_UPDATE    = 2'd2,
    ACT_LOAD      = 2'd3
  } action_t;

  // Only items that publish a result travel down the pipeline.
  typedef enum logic [1:0] {
    KIND_ACCOUNT,
    KIND_FALL,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] elapsed;       // now_ms minus the on-period base time
    logic              last_valid;
    logic [TIME_W-1:0] last_on_ms;
    logic [TIME_W-1:0] load_seconds;
  } dta_item_t;

  typedef struct packed {
    dta_item_t         item;
    logic [QUOT_W-1:0] quot;          // elapsed / 1000
    logic [FRAC_W-1:0] rem;           // elapsed % 1000
  } dta_quot_t;

endpackage : dta_pkg

`default_nettype wire

/* design/dta_front.sv */
// ----------------------------------------------------------------------------
// dta_front: input register, on/off tracking and event decode
// Registers the incoming item, decides edge, accounting or load, updates the
// on flag, base time and turn-on time, and forwards result-producing items.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          report_last_duty,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dta_pkg::action_t              in_action,
  input  wire logic                          in_level,
  input  wire logic [dta_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic [dta_pkg::TIME_W-1:0]    in_load_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dta_pkg::dta_item_t                 out_item
);
  import dta_pkg::*;

  // Input register.
  logic              held_valid;
  action_t           held_action;
  logic              held_level;
  logic [TIME_W-1:0] held_now;
  logic [TIME_W-1:0] held_load;

  // Control state. While on, the mark time equals base_time minus the
  // remainder kept downstream.
  logic              on_flag;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] turn_on_time;

  logic      held_ready;
  logic      held_move;
  logic      handle;
  logic      lvl;
  logic      is_load;
  logic      account;
  logic      fall;
  logic      rise;
  logic      emit;
  dta_item_t item_next;

  assign held_ready = !out_valid || out_ready;
  assign held_move  = held_valid && held_ready;
  assign in_ready   = !held_valid || held_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_action <= in_action;
      held_level  <= in_level;
      held_now    <= in_now_ms;
      held_load   <= in_load_seconds;
    end
  end

  always_comb begin
    handle  = 1'b0;
    lvl     = held_level;
    is_load = 1'b0;
    unique case (held_action)
      ACT_OBSERVE: begin
        handle = 1'b1;
      end
      ACT_ON_CHANGE: begin
        handle = (held_level != on_flag);
      end
      ACT_UPDATE: begin
        handle = on_flag;
        lvl    = 1'b1;
      end
      ACT_LOAD: begin
        is_load = 1'b1;
      end
      default: begin
        handle = 1'b0;
      end
    endcase

    account = handle && on_flag;
    fall    = account && !lvl;
    rise    = handle && !on_flag && lvl;
    emit    = account || is_load;

    if (is_load) begin
      item_next.kind = KIND_LOAD;
    end else if (fall) begin
      item_next.kind = KIND_FALL;
    end else begin
      item_next.kind = KIND_ACCOUNT;
    end
    item_next.elapsed      = held_now - base_time;
    item_next.last_valid   = fall && report_last_duty;
    item_next.last_on_ms   = (fall && report_last_duty) ? (held_now - turn_on_time)
                                                        : '0;
    item_next.load_seconds = held_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_flag      <= 1'b0;
      base_time    <= '0;
      turn_on_time <= '0;
    end else if (held_move) begin
      if (account || rise || is_load) begin
        base_time <= held_now;
      end
      if (rise) begin
        turn_on_time <= held_now;
        on_flag      <= 1'b1;
      end else if (fall) begin
        on_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (held_ready) begin
      out_valid <= held_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (held_move && emit) begin
      out_item <= item_next;
    end
  end

endmodule : dta_front

`default_nettype wire

/* design/dta_div1000.sv */
// ----------------------------------------------------------------------------
// dta_div1000: two-stage divide of the elapsed time by 1000
// Stage one multiplies by a fixed reciprocal, stage two forms the remainder.
// The rest of the item rides along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_div1000 (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dta_pkg::dta_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dta_pkg::dta_quot_t       out_quot
);
  import dta_pkg::*;

  logic                mul_valid;
  dta_item_t           mul_item;
  logic [QUOT_W-1:0]   mul_quot;
  logic                mul_ready;

  logic [2*TIME_W-1:0] product;
  logic [TIME_W-1:0]   back_mult;
  logic [TIME_W-1:0]   rem_full;

  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;

  assign product   = {{TIME_W{1'b0}}, in_item.elapsed} * {{TIME_W{1'b0}}, RECIP_1000};
  assign back_mult = TIME_W'(mul_quot) * MS_PER_SECOND;
  assign rem_full  = mul_item.elapsed - back_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mul_item <= in_item;
      mul_quot <= product[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && mul_ready) begin
      out_quot.item <= mul_item;
      out_quot.quot <= mul_quot;
      out_quot.rem  <= rem_full[FRAC_W-1:0];
    end
  end

endmodule : dta_div1000

`default_nettype wire

/* design/dta_accum.sv */
// ----------------------------------------------------------------------------
// dta_accum: carried remainder, seconds total and result register
// Folds the carried millisecond remainder into the divided elapsed time,
// updates the total and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_accum (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        persist_enable,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire dta_pkg::dta_quot_t          in_quot,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [dta_pkg::TIME_W-1:0]       total_seconds,
  output logic [dta_pkg::FRAC_W-1:0]       fraction_ms,
  output logic                             last_valid,
  output logic [dta_pkg::TIME_W-1:0]       last_on_ms,
  output logic                             save_request
);
  import dta_pkg::*;

  // Millisecond remainder: part of the mark time below the base while on,
  // the whole mark time while off.
  logic [FRAC_W-1:0] carry_ms;
  logic [TIME_W-1:0] accumulated_seconds;

  logic              in_move;
  logic [TIME_W:0]   full_sum;
  logic [FRAC_W:0]   rem_sum;
  logic              sec_carry;
  logic [FRAC_W-1:0] rem_fixed;
  logic [QUOT_W-1:0] secs_add;
  logic [FRAC_W-1:0] frac_new;
  logic [TIME_W-1:0] acc_next;
  logic [FRAC_W-1:0] carry_ms_next;

  assign in_ready = !out_valid || out_ready;
  assign in_move  = in_valid && in_ready;

  always_comb begin
    full_sum  = {1'b0, in_quot.item.elapsed} + (TIME_W+1)'(carry_ms);
    rem_sum   = (FRAC_W+1)'(in_quot.rem) + (FRAC_W+1)'(carry_ms);
    sec_carry = (rem_sum >= (FRAC_W+1)'(MS_PER_SECOND));
    rem_fixed = sec_carry ? FRAC_W'(rem_sum - (FRAC_W+1)'(MS_PER_SECOND))
                          : rem_sum[FRAC_W-1:0];

    // When adding the remainder wraps the 32-bit elapsed time, the true
    // elapsed value is below one second.
    if (full_sum[TIME_W]) begin
      secs_add = '0;
      frac_new = full_sum[FRAC_W-1:0];
    end else begin
      secs_add = in_quot.quot + QUOT_W'(sec_carry);
      frac_new = rem_fixed;
    end

    if (in_quot.item.kind == KIND_LOAD) begin
      acc_next      = in_quot.item.load_seconds;
      carry_ms_next = '0;
    end else begin
      acc_next      = accumulated_seconds + TIME_W'(secs_add);
      carry_ms_next = frac_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_ms            <= '0;
      accumulated_seconds <= '0;
    end else if (in_move) begin
      carry_ms            <= carry_ms_next;
      accumulated_seconds <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      total_seconds <= acc_next;
      fraction_ms   <= carry_ms_next;
      last_valid    <= in_quot.item.last_valid;
      last_on_ms    <= in_quot.item.last_on_ms;
      save_request  <= persist_enable;
    end
  end

endmodule : dta_accum

`default_nettype wire

/* design/duty_time_accumulator.sv */
// ----------------------------------------------------------------------------
// duty_time_accumulator: on-time accumulator (hour meter)
// Tracks an on/off signal from timestamped events, adds the elapsed whole
// seconds of on time to a running total and publishes that total.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (low bit first)
//  s_axis    in         tuser: action[1:0]
//                       tdata: level, now_ms[31:0], load_seconds[31:0]
//  m_axis    out        tuser: last_valid
//                       tdata: total_seconds[31:0], fraction_ms[9:0],
//                              last_on_ms[31:0], save_request
//  cfg       in         cfg_addr 0 persist_enable, 1 report_last_duty
//
// One item is accepted per cycle while s_axis_tready is high. An item
// passes through the input register, the decode register, the reciprocal
// multiply, the remainder stage and the result register.
// Reset is synchronous; there is no clearing pass.
// Every stage holds its item while the next stage is full, so s_axis_tready
// falls only when all five registers hold items and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module duty_time_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration writes.
  input  wire logic                              cfg_wr_en,
  input  wire logic [dta_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic                              cfg_wdata,
  // Event items.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // level[0], now_ms[32:1], load_seconds[64:33], zero pad above
  input  wire logic [dta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action[1:0]
  input  wire logic [dta_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // Result items.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // total_seconds[31:0], fraction_ms[41:32], last_on_ms[73:42],
  // save_request[74], zero pad above
  output logic [dta_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // last_valid[0]
  output logic [dta_pkg::OUT_USER_W-1:0]         m_axis_tuser
);
  import dta_pkg::*;

  logic persist_enable;
  logic report_last_duty;

  // Configuration registers; the user keeps the block idle whenever they are written, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      persist_enable   <= 1'b0;
      report_last_duty <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PERSIST_ENABLE:   persist_enable   <= cfg_wdata;
        REG_REPORT_LAST_DUTY: report_last_duty <= cfg_wdata;
        default:              persist_enable   <= persist_enable;
      endcase
    end
  end

  // Decode to divider.
  logic      dec_valid;
  logic      dec_ready;
  dta_item_t dec_item;

  // Divider to accumulator.
  logic      div_valid;
  logic      div_ready;
  dta_quot_t div_quot;

  logic [TIME_W-1:0] total_seconds;
  logic [FRAC_W-1:0] fraction_ms;
  logic              last_valid;
  logic [TIME_W-1:0] last_on_ms;
  logic              save_request;

  dta_front u_front (
    .clk              (clk),
    .rst              (rst),
    .report_last_duty (report_last_duty),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_action        (action_t'(s_axis_tuser[1:0])),
    .in_level         (s_axis_tdata[0]),
    .in_now_ms        (s_axis_tdata[32:1]),
    .in_load_seconds  (s_axis_tdata[64:33]),
    .out_valid        (dec_valid),
    .out_ready        (dec_ready),
    .out_item         (dec_item)
  );

  dta_div1000 u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_item   (dec_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_quot)
  );

  dta_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .persist_enable (persist_enable),
    .in_valid       (div_valid),
    .in_ready       (div_ready),
    .in_quot        (div_quot),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .total_seconds  (total_seconds),
    .fraction_ms    (fraction_ms),
    .last_valid     (last_valid),
    .last_on_ms     (last_on_ms),
    .save_request   (save_request)
  );

  assign m_axis_tdata = {5'b0, save_request, last_on_ms, fraction_ms, total_seconds};
  assign m_axis_tuser = last_valid;

endmodule : duty_time_accumulator

`default_nettype wire
